// ===== rtl/core/multiplexed_servo_pulse_generator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Servo pulse generator assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SERVO_PULSE_GENERATOR_TOP_ASSERT_SVH
`define MULTIPLEXED_SERVO_PULSE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define MSP_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define MSP_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo pulse generator package
// Sizes, item layouts and the compare halving function.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int CHANNEL_COUNT = 6;
    localparam int NUM_PAIRS     = (CHANNEL_COUNT + 1) / 2;
    localparam int PAIR_W        = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;

    localparam int CH_W   = 4;
    localparam int POS_W  = 8;
    localparam int TICK_W = 8;
    localparam int BIAS_W = 8;
    localparam int PIN_W  = 16;

    localparam logic signed [POS_W-1:0] MID_POSITION = 8'sd0;
    localparam logic [BIAS_W-1:0]       BIAS_RESET   = 8'd192;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [CH_W-1:0]         channel;
        logic signed [POS_W-1:0] position;
    } msp_item_t;

    // position store write port
    typedef struct packed {
        logic                    store_en;
        logic [PAIR_W-1:0]       row;
        logic                    lane;
        logic signed [POS_W-1:0] position;
    } msp_wr_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             wrap_flag;
    } msp_res_t;

    // low 8 bits of (pos + bias + extra) / 2, truncated toward zero
    function automatic logic [TICK_W-1:0] half_low8(
        input logic signed [POS_W-1:0] pos,
        input logic [BIAS_W-1:0]       bias,
        input logic                    extra
    );
        logic [9:0] sum;
        logic [9:0] adj;
        sum = {{2{pos[POS_W-1]}}, pos} + {2'b00, bias} + {9'd0, extra};
        adj = sum + {9'd0, sum[9]};
        return adj[8:1];
    endfunction

endpackage

// ===== rtl/core/msp_pos_store.sv =====
// ----------------------------------------------------------------------------
// Servo position store
// Channel positions kept as rows of one channel pair, one row read a cycle.
// ----------------------------------------------------------------------------
module msp_pos_store (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  msp_pkg::msp_wr_t                      wr,
    input  logic [msp_pkg::PAIR_W-1:0]            rd_row,
    output logic signed [msp_pkg::POS_W-1:0]      rd_first,
    output logic signed [msp_pkg::POS_W-1:0]      rd_second
);
    import msp_pkg::*;

    logic signed [POS_W-1:0] lane0_reg [NUM_PAIRS];
    logic signed [POS_W-1:0] lane1_reg [NUM_PAIRS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_PAIRS; r++) begin
                lane0_reg[r] <= MID_POSITION;
                // missing odd channel reads as zero
                lane1_reg[r] <= (2 * r + 1 < CHANNEL_COUNT) ? MID_POSITION : '0;
            end
        end else if (wr.store_en) begin
            if (wr.lane) begin
                lane1_reg[wr.row] <= wr.position;
            end else begin
                lane0_reg[wr.row] <= wr.position;
            end
        end
    end

    assign rd_first  = lane0_reg[rd_row];
    assign rd_second = lane1_reg[rd_row];

endmodule

// ===== rtl/core/msp_engine.sv =====
// ----------------------------------------------------------------------------
// Servo pulse timing engine
// Tick counter, phase, pair select, compares and pin toggles.
// ----------------------------------------------------------------------------
`include "multiplexed_servo_pulse_generator_top_assert.svh"

module msp_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [msp_pkg::BIAS_W-1:0]        cfg_wdata,
    input  logic                              tick_en,
    input  logic signed [msp_pkg::POS_W-1:0]  rd_first,
    input  logic signed [msp_pkg::POS_W-1:0]  rd_second,
    output logic [msp_pkg::PAIR_W-1:0]        rd_row,
    output msp_pkg::msp_res_t                 res
);
    import msp_pkg::*;

    logic [BIAS_W-1:0]        bias_reg;
    logic [TICK_W-1:0]        tick_reg, tick_next;
    logic                     phase_reg;
    logic [PAIR_W-1:0]        row_reg, row_next, step_row;
    logic [TICK_W-1:0]        cmp1_reg, cmp2_reg, cmp1_next, cmp2_next;
    logic [TICK_W-1:0]        half1, half2;
    logic [CHANNEL_COUNT-1:0] pin_reg, pin_next, toggle_mask;
    logic                     wrap, last_row;

    assign tick_next = tick_reg + 1'b1;
    assign wrap      = tick_en && (tick_next == '0);
    assign last_row  = (row_reg == PAIR_W'(NUM_PAIRS - 1));
    assign step_row  = last_row ? '0 : row_reg + 1'b1;

    // start phase looks at the next pair, centre phase at the current one
    assign rd_row    = phase_reg ? row_reg : step_row;
    assign row_next  = phase_reg ? row_reg : step_row;

    assign half1     = half_low8(rd_first, bias_reg, phase_reg);
    assign half2     = half_low8(rd_second, bias_reg, phase_reg);
    assign cmp1_next = phase_reg ? half1 : TICK_W'(0) - half1;
    assign cmp2_next = phase_reg ? half2 : TICK_W'(0) - half2;

    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            toggle_mask[i] = (PAIR_W'(i >> 1) == row_reg) &&
                             (i[0] ? (tick_next == cmp2_reg) : (tick_next == cmp1_reg));
        end
    end

    always_comb begin
        pin_next = pin_reg;
        if (wrap) begin
            if (!phase_reg && last_row) begin
                pin_next = '0;
            end
        end else if (tick_en) begin
            pin_next = pin_reg ^ toggle_mask;
        end
    end

    assign res.pin_levels = PIN_W'(pin_next);
    assign res.wrap_flag  = wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg  <= BIAS_RESET;
            tick_reg  <= '0;
            phase_reg <= 1'b0;
            row_reg   <= '0;
            cmp1_reg  <= '0;
            cmp2_reg  <= '0;
            pin_reg   <= '0;
        end else begin
            if (cfg_we) begin
                bias_reg <= cfg_wdata;
            end
            if (tick_en) begin
                tick_reg <= tick_next;
                pin_reg  <= pin_next;
            end
            if (wrap) begin
                phase_reg <= !phase_reg;
                row_reg   <= row_next;
                cmp1_reg  <= cmp1_next;
                cmp2_reg  <= cmp2_next;
            end
        end
    end

    `MSP_ASSERT_NEXT(a_pins_clear_on_return, wrap && !phase_reg && last_row, pin_reg == '0, "pins not cleared on return to pair 0")
    `MSP_ASSERT_NEXT(a_tick_holds, !tick_en, tick_reg == $past(tick_reg), "tick count moved without a tick")
    `MSP_ASSERT_NEXT(a_phase_flips, wrap, phase_reg != $past(phase_reg), "phase did not alternate on wrap")

endmodule

// ===== rtl/core/multiplexed_servo_pulse_generator_top.sv =====
// ----------------------------------------------------------------------------
// Multiplexed servo pulse generator, top level
// Result path: an accepted item lands in the input reg, then its result in the result reg.
// Throughput: 1 item per cycle; a stalled result holds the input reg and s_tready.
// Reset: synchronous active-low aresetn; bias 192, pins low, positions mid.
// ----------------------------------------------------------------------------
`include "multiplexed_servo_pulse_generator_top_assert.svh"

module multiplexed_servo_pulse_generator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: pulse_bias
    input  logic                           cfg_we,
    input  logic [msp_pkg::BIAS_W-1:0]     cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [3:0] channel, [11:4] position
    input  logic                           s_tuser,   // [0] operation
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msp_pkg::PIN_W-1:0]      m_tdata,   // [15:0] pin_levels
    output logic                           m_tuser    // [0] wrap_flag
);
    import msp_pkg::*;

    // Input register: one item held, refilled as soon as it moves on.
    logic      s1_valid_reg;
    msp_item_t s1_item_reg;

    // Result register
    logic      m_valid_reg;
    msp_res_t  m_res_reg;

    logic      out_free, fire, tick_en;
    msp_wr_t   wr;
    msp_res_t  res;
    logic [PAIR_W-1:0]       rd_row;
    logic signed [POS_W-1:0] rd_first, rd_second;

    // result slot frees up when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    // decode the held item
    assign tick_en     = fire && (s1_item_reg.op == OP_TICK);
    assign wr.store_en = fire && (s1_item_reg.op == OP_STORE) &&
                         ({1'b0, s1_item_reg.channel} < 5'(CHANNEL_COUNT));
    assign wr.row      = PAIR_W'(s1_item_reg.channel >> 1);
    assign wr.lane     = s1_item_reg.channel[0];
    assign wr.position = s1_item_reg.position;

    msp_pos_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .rd_row    (rd_row),
        .rd_first  (rd_first),
        .rd_second (rd_second)
    );

    msp_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tick_en   (tick_en),
        .rd_first  (rd_first),
        .rd_second (rd_second),
        .rd_row    (rd_row),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_item_reg.op       <= s_tuser;
            s1_item_reg.channel  <= s_tdata[3:0];
            s1_item_reg.position <= s_tdata[11:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // payload: stores report pins unchanged with wrap low
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.pin_levels;
    assign m_tuser  = m_res_reg.wrap_flag;

    `MSP_ASSERT_NEXT(a_item_kept, s1_valid_reg && !out_free, s1_valid_reg, "held item dropped")
    `MSP_ASSERT_NEXT(a_result_follows, fire, m_valid_reg, "processed item gave no result")
    `MSP_ASSERT_NOW(a_store_no_tick, wr.store_en, !tick_en, "store and tick in the same cycle")

endmodule
